FILE: rtl/fmat_pkg.sv
// Package for the first-match address translation block.
// Holds the command codes, the queued item and table entry types, and the sizing constants.
// No dependencies; every other file imports it.
`default_nettype none

package fmat_pkg;

  // Table size and derived widths.
  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Stream widths.
  localparam int S_DATA_W = 216;
  localparam int M_DATA_W = 48;

  // Command codes as they arrive on the input tuser.
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Classified operation carried through the queue.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // One translation entry as stored in the table.
  typedef struct packed {
    logic [31:0] match_ip;
    logic [15:0] match_port;
    logic [31:0] net_base;
    logic [5:0]  net_prefix;
    logic [31:0] out_ip;
    logic [15:0] out_port;
  } entry_t;

  // One classified item waiting for the back.
  typedef struct packed {
    op_t         op;
    logic [31:0] client_ip;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    entry_t      rule;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/first_match_address_translation.sv
// Top level of the first-match address translation block.
// Connects fmat_front, fmat_queue and fmat_back; depends on fmat_pkg.
`default_nettype none

// An ordered table of up to 64 translation entries. Commands arrive on the input
// stream with the command code in s_tuser: lookup, append entry, or clear table;
// each command gives exactly one result transfer. An append or clear needs no
// scan in the table logic. A lookup reads the table memory one entry per cycle,
// from the first entry on, and stops at the first entry whose address and port
// equal the destination and whose client network holds the client address. The
// single read port of the table memory sets that pace. A two-entry queue
// behind the input register keeps taking commands while a lookup runs or a
// result waits on the output.
module first_match_address_translation
  import fmat_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // client_ip, dest_ip, dest_port, rule_match_ip, rule_match_port, rule_net_base,
  // rule_net_prefix, rule_out_ip, rule_out_port, then two zero bits
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // command
  input  wire logic [1:0]          s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // result_ip, result_port
  output logic [M_DATA_W-1:0]      m_tdata,
  // translated, table_full_error
  output logic [1:0]               m_tuser
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // Input register and command classification.
  fmat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Queue between classification and execution.
  fmat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_item   (push_item),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_item  (pop_item)
  );

  // Rule table, scan and result register.
  fmat_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_item   (pop_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/fmat_front.sv
// Front of the translation block: accepts input transfers and classifies the command.
// Depends on fmat_pkg for the command codes and the item type.
`default_nettype none

module fmat_front
  import fmat_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // client_ip, dest_ip, dest_port, rule_match_ip, rule_match_port, rule_net_base,
  // rule_net_prefix, rule_out_ip, rule_out_port, then two zero bits
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // command
  input  wire logic [1:0]          s_tuser,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output item_t                    push_item
);

  logic  held;
  item_t item;
  op_t   op_dec;

  // Map the raw command code onto an operation.
  always_comb begin
    case (s_tuser)
      CMD_LOOKUP: op_dec = OP_LOOKUP;
      CMD_APPEND: op_dec = OP_APPEND;
      CMD_CLEAR:  op_dec = OP_CLEAR;
      default:    op_dec = OP_NONE;
    endcase
  end

  // One holding register; it refills in the cycle it drains.
  assign s_tready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  // Unpack the payload into the item register.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.op              <= op_dec;
      item.client_ip       <= s_tdata[31:0];
      item.dest_ip         <= s_tdata[63:32];
      item.dest_port       <= s_tdata[79:64];
      item.rule.match_ip   <= s_tdata[111:80];
      item.rule.match_port <= s_tdata[127:112];
      item.rule.net_base   <= s_tdata[159:128];
      item.rule.net_prefix <= s_tdata[165:160];
      item.rule.out_ip     <= s_tdata[197:166];
      item.rule.out_port   <= s_tdata[213:198];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fmat_queue.sv
// Short FIFO between the front and the back of the translation block.
// Depends on fmat_pkg for the item type and the queue depth.
`default_nettype none

module fmat_queue
  import fmat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign in_ready  = (fill != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_item  = slots[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!do_push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fmat_back.sv
// Back of the translation block: the rule table, the ordered scan and the result register.
// Depends on fmat_pkg for the entry and item types and the table size.
`default_nettype none

module fmat_back
  import fmat_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire item_t               q_item,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // result_ip, result_port
  output logic [M_DATA_W-1:0]      m_tdata,
  // translated, table_full_error
  output logic [1:0]               m_tuser
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  last_idx;
  logic [ADDR_W-1:0] scan_addr;
  logic              issuing;
  logic              rd_valid;
  logic              rd_last;
  entry_t            rd_data;
  entry_t            table_mem [MAX_ENTRIES];
  logic [31:0]       cur_client;
  logic [31:0]       cur_dest_ip;
  logic [15:0]       cur_dest_port;
  logic              take;
  logic              starts_scan;
  logic              scan_done;
  logic              table_full;
  logic [5:0]        prefix_eff;
  logic [31:0]       net_mask;
  logic              hit;
  logic              res_translated;
  logic              res_full;
  logic [31:0]       res_ip;
  logic [15:0]       res_port;

  assign q_ready    = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign take       = q_valid && q_ready;
  assign table_full = (count == CNT_W'(MAX_ENTRIES));
  assign last_idx   = count - 1'b1;

  // A lookup on a non-empty table needs a scan; every other command answers at once.
  assign starts_scan = take && (q_item.op == OP_LOOKUP) && (count != '0);

  // The scan stops at the first hit, or after the last entry has been tested.
  assign scan_done = (state == ST_SCAN) && rd_valid && (hit || rd_last);

  // Network mask from the stored prefix; lengths above 32 mean an exact match.
  assign prefix_eff = (rd_data.net_prefix > 6'd32) ? 6'd32 : rd_data.net_prefix;
  assign net_mask   = ~(32'hFFFF_FFFF >> prefix_eff);

  // Entry test on the word read out of the table.
  assign hit = (rd_data.match_ip == cur_dest_ip) &&
               (rd_data.match_port == cur_dest_port) &&
               ((cur_client & net_mask) == (rd_data.net_base & net_mask));

  assign m_tdata = {res_port, res_ip};
  assign m_tuser = {res_full, res_translated};

  // Table storage: appends write at the fill count, the scan reads one entry a cycle.
  always_ff @(posedge clk) begin
    if (take && (q_item.op == OP_APPEND) && !table_full) begin
      table_mem[count[ADDR_W-1:0]] <= q_item.rule;
    end
    rd_data <= table_mem[scan_addr];
  end

  // Control: command dispatch, scan sequencing and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // A result is raised when a command finishes and dropped once it is taken.
      if (scan_done || (take && !starts_scan)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_valid <= issuing && !scan_done;
      case (state)
        ST_IDLE: begin
          if (take) begin
            case (q_item.op)
              OP_LOOKUP: begin
                if (count != '0) begin
                  state     <= ST_SCAN;
                  scan_addr <= '0;
                  issuing   <= 1'b1;
                end
              end
              OP_APPEND: begin
                if (!table_full) begin
                  count <= count + 1'b1;
                end
              end
              OP_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Issue the next read until the last valid entry has gone out.
          if (scan_done) begin
            state   <= ST_IDLE;
            issuing <= 1'b0;
          end else if (issuing) begin
            if (CNT_W'(scan_addr) == last_idx) begin
              issuing <= 1'b0;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
          rd_last <= (CNT_W'(scan_addr) == last_idx);
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload and the lookup operands held for the scan.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (take) begin
        cur_client     <= q_item.client_ip;
        cur_dest_ip    <= q_item.dest_ip;
        cur_dest_port  <= q_item.dest_port;
        res_translated <= 1'b0;
        case (q_item.op)
          OP_LOOKUP: begin
            res_full <= 1'b0;
            res_ip   <= q_item.dest_ip;
            res_port <= q_item.dest_port;
          end
          OP_APPEND: begin
            res_full <= table_full;
            res_ip   <= '0;
            res_port <= '0;
          end
          default: begin
            res_full <= 1'b0;
            res_ip   <= '0;
            res_port <= '0;
          end
        endcase
      end
    end else if (rd_valid && hit) begin
      res_translated <= 1'b1;
      res_ip         <= rd_data.out_ip;
      res_port       <= rd_data.out_port;
    end
  end

endmodule

`default_nettype wire

FILE: tb/fmat_result_checker.sv
// Result checker for the first-match address translation block.
// Watches both stream channels, predicts every result from its own rule table and compares.
// Depends on fmat_pkg for the stream widths, the entry type and the operation codes.
module fmat_result_checker
  import fmat_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  input  wire logic                s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]          s_tuser,
  input  wire logic                m_tvalid,
  input  wire logic                m_tready,
  input  wire logic [M_DATA_W-1:0] m_tdata,
  input  wire logic [1:0]          m_tuser,
  output int                       error_count,
  output int                       pending_count,
  output int                       result_count,
  output int                       hit_count,
  output int                       full_count
);

  // One result transfer, in the order the fields are compared.
  typedef struct packed {
    logic        translated;
    logic [31:0] result_ip;
    logic [15:0] result_port;
    logic        table_full_error;
  } translation_t;

  // Private copy of the rule table and the results still owed by the block.
  entry_t       rule_table [MAX_ENTRIES];
  int           rule_count;
  translation_t expected_translations [$];

  initial begin
    rule_count    = 0;
    error_count   = 0;
    pending_count = 0;
    result_count  = 0;
    hit_count     = 0;
    full_count    = 0;
  end

  // Mask with the top prefix bits set; prefixes above 32 demand an exact match.
  function automatic logic [31:0] network_mask(input logic [5:0] prefix);
    if (prefix == 0) return 32'h0;
    if (prefix > 32) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF << (32 - prefix);
  endfunction

  // Applies one command to the private table and returns the result it must produce.
  function automatic translation_t translate_command(input op_t op, input logic [31:0] client,
                                                     input logic [31:0] dest_ip,
                                                     input logic [15:0] dest_port,
                                                     input entry_t rule);
    translation_t res;
    logic [31:0]  mask;
    res = '0;
    case (op)
      OP_LOOKUP: begin
        res.result_ip   = dest_ip;
        res.result_port = dest_port;
        // First entry in table order wins.
        for (int i = 0; i < rule_count && !res.translated; i++) begin
          mask = network_mask(rule_table[i].net_prefix);
          if (rule_table[i].match_ip == dest_ip && rule_table[i].match_port == dest_port &&
              (client & mask) == (rule_table[i].net_base & mask)) begin
            res.translated  = 1'b1;
            res.result_ip   = rule_table[i].out_ip;
            res.result_port = rule_table[i].out_port;
          end
        end
      end
      OP_APPEND: begin
        if (rule_count >= MAX_ENTRIES) begin
          res.table_full_error = 1'b1;
        end else begin
          rule_table[rule_count] = rule;
          rule_count++;
        end
      end
      OP_CLEAR: begin
        rule_count = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      error_count++;
      $error("%s mismatch: expected %h, got %h", name, want, seen);
    end
  endtask

  // Predict on every accepted command, compare on every accepted result.
  always @(posedge clk) begin : monitor
    logic [1:0]   pad_bits;
    entry_t       rule;
    logic [31:0]  client;
    logic [31:0]  dest_ip;
    logic [15:0]  dest_port;
    translation_t seen;
    translation_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        {pad_bits, rule.out_port, rule.out_ip, rule.net_prefix, rule.net_base, rule.match_port,
         rule.match_ip, dest_port, dest_ip, client} = s_tdata;
        expected_translations.push_back(
          translate_command(op_t'(s_tuser), client, dest_ip, dest_port, rule));
      end
      if (m_tvalid && m_tready) begin
        seen = {m_tuser[0], m_tdata[31:0], m_tdata[47:32], m_tuser[1]};
        result_count++;
        if (expected_translations.size() == 0) begin
          error_count++;
          $error("Result transfer with no command outstanding: data %h, flags %b",
                 m_tdata, m_tuser);
        end else begin
          want = expected_translations.pop_front();
          check_field("translated", 32'(want.translated), 32'(seen.translated));
          check_field("result_ip", want.result_ip, seen.result_ip);
          check_field("result_port", 32'(want.result_port), 32'(seen.result_port));
          check_field("table_full_error", 32'(want.table_full_error),
                      32'(seen.table_full_error));
          if (want.translated) hit_count++;
          if (want.table_full_error) full_count++;
        end
      end
      pending_count <= expected_translations.size();
    end
  end

endmodule

FILE: tb/first_match_address_translation_tb.sv
// Testbench top for the first-match address translation block.
// Drives commands and result backpressure; fmat_result_checker predicts and compares.
// Depends on fmat_pkg, first_match_address_translation and fmat_result_checker.
module first_match_address_translation_tb;
  import fmat_pkg::*;

  localparam int RANDOM_ITEMS     = 1900;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 100;
  localparam int CYCLE_LIMIT      = 1_000_000;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [1:0]          s_tuser  = '0;
  logic                m_tready = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;

  int error_count;
  int pending_count;
  int result_count;
  int hit_count;
  int full_count;
  int items_sent  = 0;
  int cycle_count = 0;

  // Idling controls shared between the command and result processes.
  bit sender_idles      = 1'b1;
  bit receiver_idles    = 1'b1;
  bit long_hold_pending = 1'b0;

  // Rules the block should hold now, used to aim lookups and appends at real entries.
  entry_t loaded_rules [$];

  always #5 clk = ~clk;

  first_match_address_translation i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  fmat_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .error_count   (error_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .hit_count     (hit_count),
    .full_count    (full_count)
  );

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.", pending_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Presents one command and waits for its transfer; keeps the aiming list in step.
  task automatic send_command(input op_t op, input logic [31:0] client,
                              input logic [31:0] dest_ip, input logic [15:0] dest_port,
                              input entry_t rule);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, rule.out_port, rule.out_ip, rule.net_prefix, rule.net_base,
                 rule.match_port, rule.match_ip, dest_port, dest_ip, client};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    case (op)
      OP_APPEND: if (loaded_rules.size() < MAX_ENTRIES) loaded_rules.push_back(rule);
      OP_CLEAR:  loaded_rules.delete();
      default: begin
      end
    endcase
  endtask

  // Sender pause until the block has answered everything.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic entry_t random_rule();
    entry_t r;
    r.match_ip   = $urandom;
    r.match_port = 16'($urandom);
    r.net_base   = $urandom;
    r.net_prefix = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 32))
                                               : 6'($urandom_range(33, 63));
    r.out_ip     = $urandom;
    r.out_port   = 16'($urandom);
    return r;
  endfunction

  // Appends with frequent reuse of an existing destination, so first-match order matters.
  task automatic random_append();
    entry_t r;
    entry_t earlier;
    r = random_rule();
    if (loaded_rules.size() > 0 && $urandom_range(0, 9) < 4) begin
      earlier      = loaded_rules[$urandom_range(0, loaded_rules.size() - 1)];
      r.match_ip   = earlier.match_ip;
      r.match_port = earlier.match_port;
    end
    // Exclude rule: maps the destination onto itself.
    if ($urandom_range(0, 6) == 0) begin
      r.out_ip   = r.match_ip;
      r.out_port = r.match_port;
    end
    send_command(OP_APPEND, $urandom, $urandom, 16'($urandom), r);
  endtask

  // Lookups mostly aimed at a loaded entry, with near misses and pure noise mixed in.
  task automatic random_lookup();
    entry_t      target;
    int          kind;
    logic [31:0] client;
    kind = $urandom_range(0, 9);
    if (loaded_rules.size() == 0 || kind == 9) begin
      send_command(OP_LOOKUP, $urandom, $urandom, 16'($urandom), random_rule());
    end else begin
      target = loaded_rules[$urandom_range(0, loaded_rules.size() - 1)];
      // Keep the network bits of the base, randomize the host bits.
      client = target.net_base ^ ($urandom >> target.net_prefix);
      if (kind == 7) client = client ^ 32'h8000_0000;
      if (kind == 8) target.match_port = target.match_port + 16'd1;
      send_command(OP_LOOKUP, client, target.match_ip, target.match_port, random_rule());
    end
  endtask

  // Result side: random stalls, and one long hold-off when asked.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall = LONG_HOLD_CYCLES;
      end else begin
        stall = receiver_idles ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Command side: directed checks, then random episodes of clear, fill and lookups.
  initial begin : command_source
    int episode;
    int rule_total;
    int lookup_total;
    int pick;
    int stop_at;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, clear on empty, and the unused command code.
    send_command(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, random_rule());
    send_command(OP_CLEAR, 32'h0, 32'h0, 16'h0, random_rule());
    send_command(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                 entry_t'{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF});

    // Any-client entry at the top of the ranges, a /24 entry, an exclude rule,
    // an oversized prefix, and a wider /16 shadowed by the /24.
    send_command(OP_APPEND, 32'h0, 32'h0, 16'h0,
                 entry_t'{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 6'd0, 32'h0, 16'h0});
    send_command(OP_APPEND, 32'h0, 32'h0, 16'h0,
                 entry_t'{32'h0, 16'h0, 32'hC0A8_0100, 6'd24, 32'h0A00_0001, 16'h1234});
    send_command(OP_APPEND, 32'h0, 32'h0, 16'h0,
                 entry_t'{32'h0102_0304, 16'd80, 32'h0A00_0005, 6'd32, 32'h0102_0304, 16'd80});
    send_command(OP_APPEND, 32'h0, 32'h0, 16'h0,
                 entry_t'{32'h0102_0304, 16'd80, 32'h0A00_0006, 6'd63, 32'h1111_1111, 16'h2222});
    send_command(OP_APPEND, 32'h0, 32'h0, 16'h0,
                 entry_t'{32'h0, 16'h0, 32'hC0A8_0000, 6'd16, 32'h0A00_0002, 16'h5678});
    send_command(OP_LOOKUP, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, random_rule());
    send_command(OP_LOOKUP, 32'hC0A8_01FF, 32'h0, 16'h0, random_rule());
    send_command(OP_LOOKUP, 32'hC0A8_0201, 32'h0, 16'h0, random_rule());
    send_command(OP_LOOKUP, 32'h0B00_0000, 32'h0, 16'h0, random_rule());
    send_command(OP_LOOKUP, 32'h0A00_0005, 32'h0102_0304, 16'd80, random_rule());
    send_command(OP_LOOKUP, 32'h0A00_0006, 32'h0102_0304, 16'd80, random_rule());
    send_command(OP_LOOKUP, 32'h0A00_0007, 32'h0102_0304, 16'd80, random_rule());

    // A cleared table forgets everything.
    send_command(OP_CLEAR, $urandom, $urandom, 16'($urandom), random_rule());
    send_command(OP_LOOKUP, 32'hC0A8_01FF, 32'h0, 16'h0, random_rule());
    wait_for_results();

    // Random episodes; the first one fills the table and backs up the result side.
    stop_at = items_sent + RANDOM_ITEMS;
    episode = 0;
    while (items_sent < stop_at) begin
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      if (episode == 0 || $urandom_range(0, 4) != 0) begin
        send_command(OP_CLEAR, $urandom, $urandom, 16'($urandom), random_rule());
      end
      pick = $urandom_range(0, 9);
      if (episode == 0 || pick == 0) rule_total = $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 6);
      else if (pick < 3) rule_total = $urandom_range(13, MAX_ENTRIES - 1);
      else rule_total = $urandom_range(1, 12);
      repeat (rule_total) random_append();

      if (episode == 0) begin
        long_hold_pending = 1'b1;
        sender_idles      = 1'b0;
        repeat (24) random_lookup();
        wait_for_results();
      end

      lookup_total = $urandom_range(5, 30);
      repeat (lookup_total) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_command(OP_NONE, $urandom, $urandom, 16'($urandom), random_rule());
        else if (pick == 1) random_append();
        else random_lookup();
      end
      if ($urandom_range(0, 5) == 0) wait_for_results();
      episode++;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d commands in %0d random episodes and checked %0d results.",
             items_sent, episode, result_count);
    $display("Lookups translated: %0d; appends refused on a full table: %0d.",
             hit_count, full_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
